// ===== rtl/assert_macros.svh =====
// Assertion macros for the meter RTL, included by vum_ballistics.
// Clocked, reset-gated implication checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vum_pkg.sv =====
// Shared types and constants for the VU meter with peak hold.
// No dependencies.
`default_nettype none

package vum_pkg;

    localparam int SEGMENTS_DEF   = 25;
    localparam int LEVEL_BITS_DEF = 16;

    localparam int LVL_W     = 16;
    localparam int COEF_W    = 16;
    localparam int HOLD_W    = 8;
    localparam int SEG_OUT_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LAMP = 3'd5;

    localparam logic [COEF_W-1:0] RST_ATTACK    = 16'd19661;
    localparam logic [COEF_W-1:0] RST_RELEASE   = 16'd3277;
    localparam logic [HOLD_W-1:0] RST_HOLD      = 8'd60;
    localparam logic [COEF_W-1:0] RST_DECAY     = 16'd64225;
    localparam logic [LVL_W-1:0]  RST_CLIP      = 16'd62259;
    localparam logic [LVL_W-1:0]  RST_CLIP_LAMP = 16'd64225;

    typedef struct packed {
        logic [COEF_W-1:0] attack;
        logic [COEF_W-1:0] release_c;
        logic [HOLD_W-1:0] hold;
        logic [COEF_W-1:0] decay;
        logic [LVL_W-1:0]  clip;
        logic [LVL_W-1:0]  clip_lamp;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/vum_ballistics.sv =====
// Attack/release smoothing and peak hold/decay state for the VU meter.
// Depends on vum_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vum_ballistics #(
    parameter int LEVEL_BITS = vum_pkg::LEVEL_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_step,
    input  wire [vum_pkg::LVL_W-1:0]    i_level,
    input  vum_pkg::t_cfg               i_cfg,
    output logic [vum_pkg::LVL_W-1:0]   o_smooth,
    output logic [vum_pkg::LVL_W-1:0]   o_peak
);

    localparam int LW = vum_pkg::LVL_W;
    localparam int CW = vum_pkg::COEF_W;
    localparam int HW = vum_pkg::HOLD_W;
    localparam logic [LW-1:0] LEVEL_MAX =
        (LEVEL_BITS >= LW) ? {LW{1'b1}} : LW'((64'd1 << LEVEL_BITS) - 64'd1);

    logic [LW-1:0] r_smooth, n_smooth;
    logic [LW-1:0] r_peak, n_peak;
    logic [HW-1:0] r_cnt, n_cnt;

    logic [LW-1:0]            lvl;
    logic [CW-1:0]            coef;
    logic signed [LW:0]       diff;
    logic signed [CW:0]       coef_s;
    logic signed [LW+CW+1:0]  blend_acc;
    logic [LW+CW-1:0]         decay_prod;
    logic                     rise;

    always_comb begin
        lvl        = (i_level > LEVEL_MAX) ? LEVEL_MAX : i_level;
        coef       = (lvl > r_smooth) ? i_cfg.attack : i_cfg.release_c;
        diff       = $signed({1'b0, lvl}) - $signed({1'b0, r_smooth});
        coef_s     = $signed({1'b0, coef});
        // old*2^16 + (in-old)*c + half lsb
        blend_acc  = diff * coef_s
                   + $signed({2'b00, r_smooth, 1'b1, {(CW-1){1'b0}}});
        n_smooth   = blend_acc[CW +: LW];
        decay_prod = r_peak * i_cfg.decay;
        rise       = n_smooth > r_peak;
        n_peak     = r_peak;
        n_cnt      = r_cnt;
        if (rise) begin
            n_peak = n_smooth;
            n_cnt  = i_cfg.hold;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - HW'(1);
        end else begin
            n_peak = decay_prod[CW +: LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_peak   <= '0;
            r_cnt    <= '0;
        end else if (i_step) begin
            r_smooth <= n_smooth;
            r_peak   <= n_peak;
            r_cnt    <= n_cnt;
        end
    end

    assign o_smooth = r_smooth;
    assign o_peak   = r_peak;

    `ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_step,
        $stable(r_smooth) && $stable(r_peak) && $stable(r_cnt), "state moved without a step")
    `ASSERT_NEXT(a_hold_count, i_clk, i_rst_n, i_step && !rise && r_cnt != '0,
        r_cnt == $past(r_cnt) - HW'(1) && $stable(r_peak), "hold count did not step down")
    `ASSERT_NEXT(a_attack_range, i_clk, i_rst_n, i_step && lvl >= r_smooth,
        r_smooth >= $past(r_smooth) && r_smooth <= $past(lvl), "smoothed level overshoot")

endmodule

`default_nettype wire

// ===== rtl/vu_meter_peak_hold.sv =====
// VU meter ballistics with peak hold: top level, config registers, readout stage.
// Depends on vum_pkg and vum_ballistics.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+---------------------------------------
//  input    | i_in_valid / o_in_stall       | i_level_in
//  result   | o_out_valid / i_out_stall     | o_meter_level .. o_peak_marker
//  config   | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the result side does not stall; the result is
// registered through the input register, the state update and the readout register. The
// state update is one multiply-accumulate plus the peak compare, set by the smoothing recurrence.
// Synchronous active-low reset clears state and loads register defaults.
// A stalled result holds; requests keep flowing until every stage is full.
`default_nettype none

module vu_meter_peak_hold #(
    parameter int SEGMENTS   = vum_pkg::SEGMENTS_DEF,
    parameter int LEVEL_BITS = vum_pkg::LEVEL_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [vum_pkg::LVL_W-1:0]         i_level_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [vum_pkg::LVL_W-1:0]        o_meter_level,
    output logic [vum_pkg::LVL_W-1:0]        o_peak_level,
    output logic                             o_clipping,
    output logic                             o_clip_lamp,
    output logic [vum_pkg::SEG_OUT_W-1:0]    o_lit_segments,
    output logic [vum_pkg::SEG_OUT_W-1:0]    o_peak_segment,
    output logic                             o_peak_marker,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [vum_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [vum_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int LW     = vum_pkg::LVL_W;
    localparam int SW     = vum_pkg::SEG_OUT_W;
    localparam int PROD_W = LW + $clog2(SEGMENTS + 1);

    vum_pkg::t_cfg r_cfg;

    logic          r_a_valid, r_b_valid, r_out_valid;
    logic [LW-1:0] r_level_a;
    logic          in_accept, a_fire, b_fire;

    logic [LW-1:0] smooth, peak;

    logic [LW-1:0] r_meter, r_peak;
    logic          r_clip, r_lamp, r_marker;
    logic [SW-1:0] r_lit, r_pseg;

    logic [PROD_W-1:0] meter_prod, peak_prod, meter_seg, peak_seg, seg_plus;
    logic [SW-1:0]     n_lit, n_pseg;
    logic              n_clip, n_lamp, n_marker;

    always_comb begin
        b_fire     = r_b_valid && (!r_out_valid || !i_out_stall);
        a_fire     = r_a_valid && (!r_b_valid || b_fire);
        o_in_stall = r_a_valid && !a_fire;
        in_accept  = i_in_valid && !o_in_stall;
    end

    vum_ballistics #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_ballistics (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (a_fire),
        .i_level  (r_level_a),
        .i_cfg    (r_cfg),
        .o_smooth (smooth),
        .o_peak   (peak)
    );

    always_comb begin
        meter_prod = {{(PROD_W-LW){1'b0}}, smooth} * PROD_W'(SEGMENTS);
        peak_prod  = {{(PROD_W-LW){1'b0}}, peak} * PROD_W'(SEGMENTS);
        meter_seg  = meter_prod >> LEVEL_BITS;
        peak_seg   = peak_prod >> LEVEL_BITS;
        seg_plus   = meter_seg + PROD_W'(1);
        n_lit      = seg_plus[SW-1:0];
        n_pseg     = peak_seg[SW-1:0];
        n_clip     = peak >= r_cfg.clip;
        n_lamp     = peak >= r_cfg.clip_lamp;
        n_marker   = (peak != '0) && (peak_seg < PROD_W'(SEGMENTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid         <= 1'b0;
            r_b_valid         <= 1'b0;
            r_out_valid       <= 1'b0;
            r_cfg.attack      <= vum_pkg::RST_ATTACK;
            r_cfg.release_c   <= vum_pkg::RST_RELEASE;
            r_cfg.hold        <= vum_pkg::RST_HOLD;
            r_cfg.decay       <= vum_pkg::RST_DECAY;
            r_cfg.clip        <= vum_pkg::RST_CLIP;
            r_cfg.clip_lamp   <= vum_pkg::RST_CLIP_LAMP;
        end else begin
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    vum_pkg::CFG_ATTACK:    r_cfg.attack    <= i_cfg_data;
                    vum_pkg::CFG_RELEASE:   r_cfg.release_c <= i_cfg_data;
                    vum_pkg::CFG_HOLD:      r_cfg.hold      <= i_cfg_data[vum_pkg::HOLD_W-1:0];
                    vum_pkg::CFG_DECAY:     r_cfg.decay     <= i_cfg_data;
                    vum_pkg::CFG_CLIP:      r_cfg.clip      <= i_cfg_data;
                    vum_pkg::CFG_CLIP_LAMP: r_cfg.clip_lamp <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_level_a <= i_level_in;
        end
        if (b_fire) begin
            r_meter  <= smooth;
            r_peak   <= peak;
            r_clip   <= n_clip;
            r_lamp   <= n_lamp;
            r_lit    <= n_lit;
            r_pseg   <= n_pseg;
            r_marker <= n_marker;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_meter_level  = r_meter;
    assign o_peak_level   = r_peak;
    assign o_clipping     = r_clip;
    assign o_clip_lamp    = r_lamp;
    assign o_lit_segments = r_lit;
    assign o_peak_segment = r_pseg;
    assign o_peak_marker  = r_marker;

endmodule

`default_nettype wire

// ===== verif/vu_meter_peak_hold_tb.sv =====
// Self-checking testbench for vu_meter_peak_hold: directed and burst-shaped random meter ticks,
// every result compared field by field against an in-bench ballistics and peak-hold predictor.
// Depends on vum_pkg and the vu_meter_peak_hold RTL.
module vu_meter_peak_hold_tb;
    import vum_pkg::*;

    localparam int SEG_COUNT      = SEGMENTS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENT_ITEMS  = 330;
    localparam int MAX_REPORTS    = 10;

    // Indexes the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {SET_RANDOM, SET_MIN, SET_MAX} cfg_setting_e;
    typedef enum int {PAT_NOISE, PAT_STEADY, PAT_SILENCE, PAT_LOUD, PAT_RAMP} level_pattern_e;

    typedef struct packed {
        logic [LVL_W-1:0]     meter;
        logic [LVL_W-1:0]     peak;
        logic                 clipping;
        logic                 clip_lamp;
        logic [SEG_OUT_W-1:0] lit;
        logic [SEG_OUT_W-1:0] pseg;
        logic                 marker;
    } meter_result_t;

    class meter_scoreboard;
        t_cfg                regs;
        logic [LVL_W-1:0]    smooth_lvl;
        logic [LVL_W-1:0]    peak_lvl;
        logic [HOLD_W-1:0]   hold_cnt;
        meter_result_t       meter_q[$];
        int                  failures;

        function new();
            regs = '{attack: RST_ATTACK, release_c: RST_RELEASE, hold: RST_HOLD,
                     decay: RST_DECAY, clip: RST_CLIP, clip_lamp: RST_CLIP_LAMP};
            smooth_lvl = '0;
            peak_lvl   = '0;
            hold_cnt   = '0;
            failures   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_ATTACK:    regs.attack    = data;
                CFG_RELEASE:   regs.release_c = data;
                CFG_HOLD:      regs.hold      = data[HOLD_W-1:0];
                CFG_DECAY:     regs.decay     = data;
                CFG_CLIP:      regs.clip      = data;
                CFG_CLIP_LAMP: regs.clip_lamp = data;
                default: ;
            endcase
        endfunction

        function logic [LVL_W-1:0] blend(logic [LVL_W-1:0] prev, logic [LVL_W-1:0] lvl,
                                         logic [COEF_W-1:0] c);
            logic [63:0] acc;
            acc = 64'(prev) * (64'd65536 - 64'(c)) + 64'(lvl) * 64'(c) + 64'd32768;
            acc = acc >> 16;
            return (acc > 64'hFFFF) ? 16'hFFFF : acc[LVL_W-1:0];
        endfunction

        function logic [63:0] segment_of(logic [LVL_W-1:0] lvl);
            return (64'(lvl) * 64'(SEG_COUNT)) >> LEVEL_BITS_DEF;
        endfunction

        function void note_level(logic [LVL_W-1:0] lvl);
            meter_result_t r;
            logic [63:0]   pseg;
            logic [63:0]   lit;
            logic [63:0]   decayed;
            smooth_lvl = blend(smooth_lvl, lvl,
                               (lvl > smooth_lvl) ? regs.attack : regs.release_c);
            if (smooth_lvl > peak_lvl) begin
                peak_lvl = smooth_lvl;
                hold_cnt = regs.hold;
            end else if (hold_cnt != 0) begin
                hold_cnt = hold_cnt - 1'b1;
            end else begin
                decayed  = (64'(peak_lvl) * 64'(regs.decay)) >> 16;
                peak_lvl = decayed[LVL_W-1:0];
            end
            pseg        = segment_of(peak_lvl);
            lit         = segment_of(smooth_lvl) + 64'd1;
            r.meter     = smooth_lvl;
            r.peak      = peak_lvl;
            r.clipping  = (peak_lvl >= regs.clip);
            r.clip_lamp = (peak_lvl >= regs.clip_lamp);
            r.lit       = lit[SEG_OUT_W-1:0];
            r.pseg      = pseg[SEG_OUT_W-1:0];
            r.marker    = (peak_lvl != 0) && (pseg < 64'(SEG_COUNT));
            meter_q.push_back(r);
        endfunction

        function void check_result(meter_result_t got);
            meter_result_t want;
            if (meter_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: meter=%0d peak=%0d", got.meter, got.peak);
                return;
            end
            want = meter_q.pop_front();
            if (got.meter !== want.meter || got.peak !== want.peak
                    || got.clipping !== want.clipping || got.clip_lamp !== want.clip_lamp
                    || got.lit !== want.lit || got.pseg !== want.pseg
                    || got.marker !== want.marker) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"mismatch: exp meter=%0d peak=%0d clip=%0b lamp=%0b lit=%0d ",
                              "pseg=%0d mark=%0b / got meter=%0d peak=%0d clip=%0b lamp=%0b ",
                              "lit=%0d pseg=%0d mark=%0b"},
                             want.meter, want.peak, want.clipping, want.clip_lamp, want.lit,
                             want.pseg, want.marker, got.meter, got.peak, got.clipping,
                             got.clip_lamp, got.lit, got.pseg, got.marker);
            end
        endfunction

        function int pending();
            return meter_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [LVL_W-1:0]      i_level_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [LVL_W-1:0]      o_meter_level;
    logic [LVL_W-1:0]      o_peak_level;
    logic                  o_clipping;
    logic                  o_clip_lamp;
    logic [SEG_OUT_W-1:0]  o_lit_segments;
    logic [SEG_OUT_W-1:0]  o_peak_segment;
    logic                  o_peak_marker;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;

    meter_scoreboard sb;
    meter_result_t   seen;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              hold_off_cycles;
    int              quiet_cycles;

    logic [LVL_W-1:0] reset_ticks [7] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          16'h9C40, 16'h0000, 16'h0000};
    logic [LVL_W-1:0] edge_ticks [12] = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                                          16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0001, 16'h8000, 16'h8000, 16'h0064};

    vu_meter_peak_hold u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_level_in     (i_level_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_meter_level  (o_meter_level),
        .o_peak_level   (o_peak_level),
        .o_clipping     (o_clipping),
        .o_clip_lamp    (o_clip_lamp),
        .o_lit_segments (o_lit_segments),
        .o_peak_segment (o_peak_segment),
        .o_peak_marker  (o_peak_marker),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: stall pattern, with a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_out_stall = 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_meter_level, o_peak_level, o_clipping, o_clip_lamp,
                     o_lit_segments, o_peak_segment, o_peak_marker};
            sb.check_result(seen);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_level(input logic [LVL_W-1:0] lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_level_in = lvl;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_level(lvl);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic configure(input cfg_setting_e setting);
        logic [CFG_DAT_W-1:0] v [6];
        for (int i = 0; i < 6; i++)
            v[i] = (setting == SET_MIN) ? '0 : (setting == SET_MAX) ? '1 : CFG_DAT_W'($urandom);
        if (setting == SET_RANDOM) begin
            // short holds most of the time and slow decays half of the time, so the peak actually moves
            if ($urandom_range(3) != 0) v[2][HOLD_W-1:0] = HOLD_W'($urandom_range(12));
            if ($urandom_range(1) != 0) v[3] = 16'hFFFF - CFG_DAT_W'($urandom_range(4000));
        end
        write_cfg(CFG_ATTACK, v[0]);
        write_cfg(CFG_RELEASE, v[1]);
        write_cfg(CFG_HOLD, v[2]);
        write_cfg(CFG_DECAY, v[3]);
        write_cfg(CFG_CLIP, v[4]);
        write_cfg(CFG_CLIP_LAMP, v[5]);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_burst(inout int sent);
        level_pattern_e   pat;
        int               len;
        logic [LVL_W-1:0] base;
        logic [LVL_W-1:0] lvl;
        pat  = level_pattern_e'($urandom_range(4));
        len  = $urandom_range(1, 40);
        base = LVL_W'($urandom);
        for (int k = 0; k < len; k++) begin
            case (pat)
                PAT_NOISE:   lvl = LVL_W'($urandom);
                PAT_STEADY:  lvl = base;
                PAT_SILENCE: lvl = '0;
                PAT_LOUD:    lvl = 16'hFFFF - LVL_W'($urandom_range(255));
                default:     lvl = base + LVL_W'(k * 1500);
            endcase
            send_level(lvl);
            sent++;
        end
    endtask

    initial begin
        int sent;
        sb = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_level_in      = '0;
        i_out_stall     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        send_idle_pct   = 12;
        recv_stall_pct  = 52;
        hold_off_cycles = 0;
        quiet_cycles    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults straight after reset: silence, full scale, equal input, fall
        foreach (reset_ticks[i]) send_level(reset_ticks[i]);
        drain();

        // instant coefficients, two-tick hold with fast decay, zero clip threshold,
        // hold data with upper bits set, then writes to unused indexes
        write_cfg(CFG_ATTACK, 16'hFFFF);
        write_cfg(CFG_RELEASE, 16'hFFFF);
        write_cfg(CFG_HOLD, 16'hA502);
        write_cfg(CFG_DECAY, 16'h4000);
        write_cfg(CFG_CLIP, 16'h0000);
        write_cfg(CFG_CLIP_LAMP, 16'hFFFF);
        write_cfg(CFG_SPARE_A, 16'h0000);
        write_cfg(CFG_SPARE_B, 16'h0001);
        i_cfg_valid = 1'b0;
        foreach (edge_ticks[i]) send_level(edge_ticks[i]);

        for (int s = 0; s < 6; s++) begin
            drain();
            configure((s == 1) ? SET_MAX : (s == 3) ? SET_MIN : SET_RANDOM);
            send_idle_pct  = (s < 2) ? 12 : (s < 4) ? 52 : 0;
            recv_stall_pct = (s < 2) ? 52 : (s < 4) ? 12 : 0;
            hold_off_cycles = 50 + $urandom_range(50);
            sent = 0;
            while (sent < SEGMENT_ITEMS) send_burst(sent);
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== vu_meter_peak_hold.f =====
+incdir+rtl
rtl/vum_pkg.sv
rtl/vum_ballistics.sv
rtl/vu_meter_peak_hold.sv
verif/vu_meter_peak_hold_tb.sv
